// ----- design/ltne_pkg.sv -----
// ltne_pkg: shared types and constants for the local timer next expiry block
// no dependencies; imported by ltne_muldiv, local_timer_next_expiry and the testbench

package ltne_pkg;

    // data widths
    localparam int TIME_W     = 64;
    localparam int CNT_W      = 32;
    localparam int PER_W      = CNT_W + 1;
    localparam int SH_W       = 3;
    localparam int CTRL_W     = 2;
    localparam int CFG_IDX_W  = 2;

    // iteration counts of the shared unit
    localparam int DIV_STEPS  = TIME_W;
    localparam int MUL_STEPS  = PER_W;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    // control register bits
    localparam int CTRL_MASK_BIT     = 0;
    localparam int CTRL_PERIODIC_BIT = 1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMER_CONTROL = 2'd0,
        REG_DIVIDE_SHIFT  = 2'd1,
        REG_INITIAL_COUNT = 2'd2,
        REG_LOAD_TIME     = 2'd3
    } cfg_reg_t;

    // operation of the shared divide/multiply unit
    typedef enum logic {
        MDU_DIV = 1'b0,
        MDU_MUL = 1'b1
    } mdu_op_t;

    // request from the sequencer to the shared unit
    typedef struct packed {
        logic    start;
        mdu_op_t op;
    } mdu_req_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_SCALE  = 3'd1,
        S_DECIDE = 3'd2,
        S_DIV    = 3'd3,
        S_MUL    = 3'd4,
        S_ADD    = 3'd5,
        S_OUT    = 3'd6
    } state_t;

endpackage

// ----- design/ltne_muldiv.sv -----
// ltne_muldiv: iterative unit around one shared 64-bit adder
// restoring radix-2 divide (64 / 33 bits) or shift-add multiply (64 x 33 bits)
// depends on ltne_pkg

module ltne_muldiv (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ltne_pkg::mdu_req_t            req,
    input  logic [ltne_pkg::TIME_W-1:0]   opnd_a,
    input  logic [ltne_pkg::PER_W-1:0]    opnd_p,
    output logic                          done,
    output logic [ltne_pkg::TIME_W-1:0]   result
);
    import ltne_pkg::*;

    localparam int PAD_TRIAL = TIME_W - PER_W - 1;
    localparam int PAD_PER   = TIME_W - PER_W;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    mdu_op_t               op_reg, op_next;
    logic [TIME_W-1:0]     a_reg, a_next;
    logic [TIME_W-1:0]     r_reg, r_next;
    logic [PER_W-1:0]      p_reg, p_next;

    logic [TIME_W-1:0]     add_a;
    logic [TIME_W-1:0]     add_b;
    logic                  add_sub;
    logic [TIME_W:0]       sum;
    logic                  carry;

    // shared adder operands
    always_comb
    begin
        if (op_reg == MDU_DIV)
        begin
            add_a   = {{PAD_TRIAL{1'b0}}, r_reg[PER_W-1:0], a_reg[TIME_W-1]};
            add_b   = {{PAD_PER{1'b0}}, p_reg};
            add_sub = 1'b1;
        end
        else
        begin
            add_a   = r_reg;
            add_b   = a_reg;
            add_sub = 1'b0;
        end
    end

    // the one adder/subtractor
    assign sum   = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                 + {{TIME_W{1'b0}}, add_sub};
    assign carry = sum[TIME_W];

    // step logic
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        r_next    = r_reg;
        p_next    = p_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            a_next    = opnd_a;
            r_next    = '0;
            p_next    = opnd_p;
            cnt_next  = (req.op == MDU_DIV) ? STEP_CNT_W'(DIV_STEPS - 1)
                                            : STEP_CNT_W'(MUL_STEPS - 1);
        end
        else if (busy_reg)
        begin
            if (op_reg == MDU_DIV)
            begin
                // keep the difference when the trial remainder covers the period
                r_next = carry ? {{PAD_PER{1'b0}}, sum[PER_W-1:0]}
                               : {{PAD_PER{1'b0}}, add_a[PER_W-1:0]};
                a_next = {a_reg[TIME_W-2:0], carry};
            end
            else
            begin
                // add the shifted multiplicand for each set multiplier bit
                if (p_reg[0])
                begin
                    r_next = sum[TIME_W-1:0];
                end
                a_next = {a_reg[TIME_W-2:0], 1'b0};
                p_next = {1'b0, p_reg[PER_W-1:1]};
            end
            cnt_next = cnt_reg - STEP_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        a_reg  <= a_next;
        r_reg  <= r_next;
        p_reg  <= p_next;
    end

    assign done   = done_reg;
    assign result = (op_reg == MDU_DIV) ? a_reg : r_reg;

endmodule

// ----- design/local_timer_next_expiry.sv -----
// local_timer_next_expiry: sequencer and timer registers around ltne_muldiv, uses ltne_pkg
// out_valid rises in S_OUT after S_SCALE and S_DECIDE when masked, expired or periodic with
// zero count; a live one-shot passes S_ADD as well, and periodic mode runs the 64-step
// divide (S_DIV) and 33-step multiply (S_MUL) in ltne_muldiv before S_ADD. One transaction
// at a time; the next is accepted the cycle after the result is taken.
// Reset (rst_n, async low) masks the timer and clears held next time, shift, count and load.

module local_timer_next_expiry (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration writes
    input  logic                                 cfg_wr_en,
    input  logic [ltne_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ltne_pkg::TIME_W-1:0]          cfg_wr_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [ltne_pkg::TIME_W-1:0]   now_time,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 armed,
    output logic signed [ltne_pkg::TIME_W-1:0]   expiry_time,
    output logic signed [ltne_pkg::TIME_W-1:0]   held_next_time
);
    import ltne_pkg::*;

    state_t               state_reg, state_next;

    logic [CTRL_W-1:0]    ctrl_reg;
    logic [SH_W-1:0]      shift_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [TIME_W-1:0]    load_reg;

    logic [TIME_W-1:0]    now_reg;
    logic [TIME_W-1:0]    elapsed_reg;
    logic [TIME_W-1:0]    ticks_reg;
    logic                 armed_reg;
    logic [TIME_W-1:0]    deadline_reg;

    logic [PER_W-1:0]     period;
    logic [TIME_W-1:0]    diff;
    logic                 masked;
    logic                 periodic;
    logic                 oneshot_live;
    logic                 in_accept;

    mdu_req_t             mdu_req;
    logic                 mdu_done;
    logic [TIME_W-1:0]    mdu_result;
    logic [TIME_W-1:0]    mdu_opnd_a;

    assign period       = {1'b0, count_reg} + PER_W'(1);
    assign diff         = now_reg - load_reg;
    assign masked       = ctrl_reg[CTRL_MASK_BIT];
    assign periodic     = ctrl_reg[CTRL_PERIODIC_BIT];
    assign oneshot_live = elapsed_reg[TIME_W-1]
                        || (elapsed_reg < {{(TIME_W-CNT_W){1'b0}}, count_reg});
    assign in_accept    = in_valid && !in_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg  <= CTRL_W'(1);
            shift_reg <= '0;
            count_reg <= '0;
            load_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TIMER_CONTROL: ctrl_reg  <= cfg_wr_data[CTRL_W-1:0];
                REG_DIVIDE_SHIFT:  shift_reg <= cfg_wr_data[SH_W-1:0];
                REG_INITIAL_COUNT: count_reg <= cfg_wr_data[CNT_W-1:0];
                REG_LOAD_TIME:     load_reg  <= cfg_wr_data;
                default:           ctrl_reg  <= ctrl_reg;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                priority if (masked)
                begin
                    state_next = S_OUT;
                end
                else if (periodic)
                begin
                    state_next = (count_reg == '0) ? S_OUT : S_DIV;
                end
                else
                begin
                    state_next = oneshot_live ? S_ADD : S_OUT;
                end
            end
            S_DIV:
            begin
                if (mdu_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mdu_done)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall      = 1'b1;
        out_valid     = 1'b0;
        mdu_req.start = 1'b0;
        mdu_req.op    = MDU_DIV;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
            end
            S_DECIDE:
            begin
                mdu_req.start = !masked && periodic && (count_reg != '0);
                mdu_req.op    = MDU_DIV;
            end
            S_DIV:
            begin
                mdu_req.start = mdu_done;
                mdu_req.op    = MDU_MUL;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // multiplicand is quotient plus one, dividend is the scaled elapsed time
    assign mdu_opnd_a = (state_reg == S_DIV) ? (mdu_result + TIME_W'(1)) : elapsed_reg;

    ltne_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mdu_req),
        .opnd_a (mdu_opnd_a),
        .opnd_p (period),
        .done   (mdu_done),
        .result (mdu_result)
    );

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // held next time and armed flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadline_reg <= '0;
            armed_reg    <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DECIDE)
            begin
                armed_reg <= !masked && (periodic ? (count_reg != '0) : oneshot_live);
            end
            if (state_reg == S_ADD)
            begin
                deadline_reg <= load_reg + (ticks_reg << shift_reg);
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            now_reg <= now_time;
        end
        if (state_reg == S_SCALE)
        begin
            elapsed_reg <= $unsigned($signed(diff) >>> shift_reg);
        end
        if (state_reg == S_DECIDE)
        begin
            ticks_reg <= {{(TIME_W-PER_W){1'b0}}, period};
        end
        else if (state_reg == S_MUL && mdu_done)
        begin
            ticks_reg <= mdu_result;
        end
    end

    assign armed          = armed_reg;
    assign expiry_time    = armed_reg ? deadline_reg : '1;
    assign held_next_time = deadline_reg;

endmodule

// ----- tb/sv/local_timer_next_expiry_tb.sv -----
`timescale 1ns / 100ps
// local_timer_next_expiry_tb: self-checking testbench for the local timer next expiry block
// depends on ltne_pkg and local_timer_next_expiry; random stimulus with a scoreboard class

module local_timer_next_expiry_tb;
    import ltne_pkg::*;

    localparam int RANDOM_PHASES    = 27;
    localparam int ITEMS_PER_PHASE  = 50;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 120;
    localparam int MAX_REPORTS      = 30;

    localparam logic [TIME_W-1:0] TIME_MIN  = {1'b1, {(TIME_W-1){1'b0}}};
    localparam logic [TIME_W-1:0] TIME_MAX  = {1'b0, {(TIME_W-1){1'b1}}};
    localparam logic [TIME_W-1:0] ALL_ONES  = {TIME_W{1'b1}};

    // timer_control encodings
    localparam logic [CTRL_W-1:0] CTRL_ONESHOT       = 2'b00;
    localparam logic [CTRL_W-1:0] CTRL_MASKED        = 2'b01;
    localparam logic [CTRL_W-1:0] CTRL_PERIODIC      = 2'b10;
    localparam logic [CTRL_W-1:0] CTRL_MASKED_PERIOD = 2'b11;

    // one result of a timer evaluation
    typedef struct {
        logic              armed;
        logic [TIME_W-1:0] expiry;
        logic [TIME_W-1:0] held;
    } expiry_t;

    // shadow timer registers, deadline prediction and result matching
    class expiry_board;
        logic [CTRL_W-1:0] ctrl;
        logic [SH_W-1:0]   shift;
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] load;
        logic [TIME_W-1:0] deadline;
        expiry_t           due[$];
        int                errors;
        int                evaluations;
        int                armed_seen;

        function void reset_state();
            ctrl        = CTRL_MASKED;
            shift       = '0;
            count       = '0;
            load        = '0;
            deadline    = '0;
            errors      = 0;
            evaluations = 0;
            armed_seen  = 0;
            due.delete();
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void apply_write(cfg_reg_t idx, logic [TIME_W-1:0] data);
            case (idx)
                REG_TIMER_CONTROL: ctrl  = data[CTRL_W-1:0];
                REG_DIVIDE_SHIFT:  shift = data[SH_W-1:0];
                REG_INITIAL_COUNT: count = data[CNT_W-1:0];
                REG_LOAD_TIME:     load  = data;
                default: ;
            endcase
        endfunction

        // work out the next expiry for an accepted time stamp
        function void note_input(logic [TIME_W-1:0] now);
            expiry_t                  r;
            logic signed [TIME_W-1:0] diff;
            logic [TIME_W-1:0]        elapsed;
            logic [TIME_W-1:0]        period;
            logic [TIME_W-1:0]        ticks;
            logic                     fires;
            fires  = 1'b0;
            ticks  = '0;
            period = {{(TIME_W-CNT_W){1'b0}}, count} + 64'd1;
            if (!ctrl[CTRL_MASK_BIT]) begin
                diff    = now - load;
                elapsed = diff >>> shift;
                if (ctrl[CTRL_PERIODIC_BIT]) begin
                    // unsigned divide, so a negative elapsed gives a huge quotient
                    if (count != '0) begin
                        ticks = (elapsed / period + 64'd1) * period;
                        fires = 1'b1;
                    end
                end else if (elapsed[TIME_W-1] ||
                             elapsed < {{(TIME_W-CNT_W){1'b0}}, count}) begin
                    ticks = period;
                    fires = 1'b1;
                end
                if (fires)
                    deadline = load + (ticks << shift);
            end
            r.armed  = fires;
            r.expiry = fires ? deadline : ALL_ONES;
            r.held   = deadline;
            due.push_back(r);
        endfunction

        function void report(string field, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
        endfunction

        // compare one result transaction with the oldest prediction
        function void check_result(logic a, logic [TIME_W-1:0] e, logic [TIME_W-1:0] h);
            expiry_t w;
            if (due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("unexpected result transaction: armed %0d expiry %0d", a, $signed(e));
                return;
            end
            w = due.pop_front();
            evaluations++;
            if (w.armed)
                armed_seen++;
            if (a !== w.armed)
                report("armed", {{(TIME_W-1){1'b0}}, w.armed}, {{(TIME_W-1){1'b0}}, a});
            if (e !== w.expiry)
                report("expiry_time", w.expiry, e);
            if (h !== w.held)
                report("held_next_time", w.held, h);
        endfunction
    endclass

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     cfg_wr_en   = 1'b0;
    cfg_reg_t                 cfg_index   = REG_TIMER_CONTROL;
    logic [TIME_W-1:0]        cfg_wr_data = '0;
    logic                     in_valid    = 1'b0;
    logic                     in_stall;
    logic signed [TIME_W-1:0] now_time    = '0;
    logic                     out_valid;
    logic                     out_stall   = 1'b0;
    logic                     armed;
    logic signed [TIME_W-1:0] expiry_time;
    logic signed [TIME_W-1:0] held_next_time;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        hold_req    = 1'b0;
    int          settings    = 0;
    expiry_board book        = new;

    local_timer_next_expiry uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .now_time       (now_time),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .armed          (armed),
        .expiry_time    (expiry_time),
        .held_next_time (held_next_time)
    );

    // clock
    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // offer one time stamp and wait for the transaction
    task automatic offer(input logic [TIME_W-1:0] t);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        now_time <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        book.note_input(t);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [TIME_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        book.apply_write(idx, data);
        @(posedge clk);
    endtask

    // reprogram all timer registers once the block has drained
    task automatic program_timer(input logic [CTRL_W-1:0] ctrl, input logic [SH_W-1:0] shift,
                                 input logic [CNT_W-1:0] count, input logic [TIME_W-1:0] load);
        logic [TIME_W-1:0] junk;
        in_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        junk = {$urandom, $urandom};
        // unused upper bits carry noise, the block must ignore them
        write_reg(REG_TIMER_CONTROL, {junk[TIME_W-1:CTRL_W], ctrl});
        write_reg(REG_DIVIDE_SHIFT, {junk[TIME_W-1:SH_W], shift});
        write_reg(REG_INITIAL_COUNT, {junk[TIME_W-1:CNT_W], count});
        write_reg(REG_LOAD_TIME, load);
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    // random timer setting, biased toward armed modes and corner counts
    task automatic program_random();
        logic [CTRL_W-1:0] ctrl;
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] load;
        int unsigned       pick;
        pick = $urandom_range(0, 9);
        ctrl = (pick == 0) ? CTRL_MASKED :
               (pick == 1) ? CTRL_MASKED_PERIOD :
               (pick <= 5) ? CTRL_PERIODIC : CTRL_ONESHOT;
        case ($urandom_range(0, 4))
            0:       count = '0;
            1:       count = '1;
            2:       count = $urandom_range(1, 20);
            default: count = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0:       load = TIME_MIN;
            1:       load = TIME_MAX;
            2:       load = '0;
            default: load = {$urandom, $urandom};
        endcase
        program_timer(ctrl, SH_W'($urandom_range(0, 7)), count, load);
    endtask

    // time stamp near the interesting points of the current setting
    function automatic logic [TIME_W-1:0] pick_now();
        logic signed [31:0] d;
        logic [TIME_W-1:0]  offset;
        int unsigned        lsb_span;
        lsb_span = (1 << book.shift) - 1;
        case ($urandom_range(0, 9))
            0, 1:
                return {$urandom, $urandom};
            2, 3, 4, 5:
            begin
                // around the one-shot boundary and period multiples
                d      = $signed($urandom_range(0, 6)) - 3;
                offset = ({{(TIME_W-CNT_W){1'b0}}, book.count} + {{32{d[31]}}, d})
                         << book.shift;
                return book.load + offset + $urandom_range(0, lsb_span);
            end
            6, 7:
            begin
                offset = TIME_W'($urandom_range(0, 2000));
                return $urandom_range(0, 1) ? book.load + offset : book.load - offset;
            end
            8:
                return book.load - {32'd0, $urandom};
            default:
                case ($urandom_range(0, 4))
                    0:       return TIME_MIN;
                    1:       return TIME_MAX;
                    2:       return '0;
                    3:       return ALL_ONES;
                    default: return book.load;
                endcase
        endcase
    endfunction

    // result side: check transactions, random stall, one long hold-off
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                book.check_result(armed, expiry_time, held_next_time);
            if (hold_req)
            begin
                hold_left = LONG_HOLD_CYCLES;
                hold_req <= 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // main sequence
    initial
    begin
        int phase;
        int n;
        book.reset_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // masked timer keeps the held deadline
        program_timer(CTRL_MASKED, 3'd0, 32'd0, 64'd0);
        offer(64'd0);
        offer(TIME_MAX);
        // periodic with zero count
        program_timer(CTRL_PERIODIC, 3'd0, 32'd0, 64'd0);
        offer(64'd12345);
        // periodic, small count, including negative elapsed
        program_timer(CTRL_PERIODIC, 3'd0, 32'd9, 64'd1000);
        offer(64'd1000);
        offer(64'd1005);
        offer(64'd1010);
        offer(64'd999);
        // periodic, widest count and shift at the time extremes
        program_timer(CTRL_PERIODIC, 3'd7, '1, TIME_MIN);
        offer(TIME_MAX);
        offer(TIME_MIN);
        // one-shot before and at the count, and negative elapsed
        program_timer(CTRL_ONESHOT, 3'd2, 32'd100, -64'sd50);
        offer(-64'sd50);
        offer(64'sd350);
        offer(64'sd349);
        offer(-64'sd58);
        // one-shot with zero count: expired unless elapsed is negative
        program_timer(CTRL_ONESHOT, 3'd0, 32'd0, TIME_MAX);
        offer(TIME_MAX);
        offer(TIME_MIN);
        offer(TIME_MAX - 64'd1);
        // masked while periodic is set
        program_timer(CTRL_MASKED_PERIOD, 3'd5, 32'd7, 64'd0);
        offer(ALL_ONES);

        // random phases: sender-light, receiver-light, then no idling
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase * 3 / RANDOM_PHASES)
                0:
                begin
                    tx_idle_pct = 19;
                    rx_idle_pct = 64;
                end
                1:
                begin
                    tx_idle_pct = 64;
                    rx_idle_pct = 19;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            program_random();
            // long receiver hold-off while items keep coming
            if (phase == 20)
                hold_req <= 1'b1;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                offer(pick_now());
        end

        in_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d timer evaluations over %0d register settings", book.evaluations,
                 settings);
        $display("%0d evaluations armed, %0d with no expiry", book.armed_seen,
                 book.evaluations - book.armed_seen);
        if (book.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/ltne_pkg.sv
design/ltne_muldiv.sv
design/local_timer_next_expiry.sv
tb/sv/local_timer_next_expiry_tb.sv
